// ===== sv/assert_macros.svh =====
// Assertion helpers used by the datapath. Both sample on the rising edge of clk
// and are switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ckmp_pkg.sv =====
`timescale 1ns / 1ps

package ckmp_pkg;

  localparam int PATTERN_MAX_DEFAULT = 8;

  localparam int CHAR_W      = 8;
  localparam int PAT_BYTES_W = 64;
  localparam int PAT_LEN_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SEARCH
  } ckmp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_write;
    logic load_item;
    logic build_step;
    logic search_step;
    logic finish;
  } ckmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_known;
    logic build_done;
    logic step_done;
    logic out_blocked;
  } ckmp_status_t;

  // Fold ASCII upper case letters to lower case; other bytes pass unchanged.
  function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== sv/caseless_kmp_substring_matcher.sv =====
`timescale 1ns / 1ps
// Each text byte is taken as one beat, then one search step is made per failure link followed,
//   plus the step that advances the prefix; the next byte waits until that step is done.
// A result is registered on the output by the step that finishes its ending beat, which waits
//   while an earlier result is still held by out_stall.
// A pattern write rebuilds the failure table while both inputs are stalled.
// Reset (rst, synchronous, active high) clears pattern, table, search state and result valid.
module caseless_kmp_substring_matcher
  import ckmp_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // Text beats.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAR_W-1:0]      text_char,
  input  logic                   end_of_text,
  input  logic                   empty_text,
  // Result beats.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // The controller sequences three activities: taking a beat (text or
  // configuration), rebuilding the failure table one step per cycle after a
  // pattern change, and walking the failure links for one text byte, one link
  // per cycle. The datapath holds the pattern, the table, the search state and
  // the result register, so a finished result can wait on out_stall while the
  // next text beat is already taken.
  ckmp_cmd_t    cmd;
  ckmp_status_t status;

  ckmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Both pattern and text bytes are folded from A-Z to a-z inside the
  // datapath. The used pattern length is clamped to PATTERN_MAX.
  ckmp_datapath #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .empty_text  (empty_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found)
  );

endmodule

// ===== sv/ckmp_ctrl.sv =====
`timescale 1ns / 1ps

module ckmp_ctrl
  import ckmp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  ckmp_status_t status,
  output ckmp_cmd_t    cmd
);

  ckmp_state_t state;
  ckmp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cfg_ready  = 1'b0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        // A configuration beat takes priority over a text beat.
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (status.cfg_known) begin
            state_next = ST_BUILD;
          end
        end else if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_SEARCH;
        end
      end
      ST_BUILD: begin
        if (status.build_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.build_step = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (!status.step_done) begin
          cmd.search_step = 1'b1;
        end else if (!status.out_blocked) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ckmp_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ckmp_datapath
  import ckmp_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ckmp_cmd_t              cmd,
  output ckmp_status_t           status,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [CHAR_W-1:0]      text_char,
  input  logic                   end_of_text,
  input  logic                   empty_text,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   found
);

  localparam int CNT_W = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [PAT_BYTES_W-1:0] pattern_bytes;
  logic [PAT_LEN_W-1:0]   pattern_length;
  logic [CNT_W-1:0]       failure_table [PATTERN_MAX];
  logic [CNT_W-1:0]       matched_prefix;
  logic                   found_flag;

  // Table build pointers.
  logic [CNT_W-1:0] bld_i;
  logic [CNT_W-1:0] bld_len;

  // Item being searched.
  logic [CNT_W-1:0]  j;
  logic [CHAR_W-1:0] char_r;
  logic              ends_r;
  logic              skip_r;

  logic [CNT_W-1:0]  used_len;
  logic [CHAR_W-1:0] pat_i;
  logic [CHAR_W-1:0] pat_len;
  logic [CHAR_W-1:0] pat_j;
  logic [CNT_W-1:0]  rd_ptr;
  logic [IDX_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  ft_rd;
  logic              j_hit;
  logic [CNT_W-1:0]  new_j;
  logic              new_found;

  function automatic logic [CHAR_W-1:0] pat_at(input logic [PAT_BYTES_W-1:0] pb,
                                               input logic [IDX_W-1:0] k);
    return fold_byte(pb[CHAR_W*k +: CHAR_W]);
  endfunction

  assign used_len = (pattern_length > PAT_LEN_W'(PATTERN_MAX)) ? CNT_W'(PATTERN_MAX)
                                                               : pattern_length[CNT_W-1:0];

  assign pat_i   = pat_at(pattern_bytes, bld_i[IDX_W-1:0]);
  assign pat_len = pat_at(pattern_bytes, bld_len[IDX_W-1:0]);
  assign pat_j   = pat_at(pattern_bytes, j[IDX_W-1:0]);

  // One read port on the failure table, shared by the build and the search.
  assign rd_ptr  = cmd.build_step ? (bld_len - 1'b1) : (j - 1'b1);
  assign rd_addr = rd_ptr[IDX_W-1:0];
  assign ft_rd   = failure_table[rd_addr];

  assign j_hit     = (pat_j == char_r);
  assign new_j     = j + CNT_W'(j_hit);
  assign new_found = !skip_r && (new_j >= used_len);

  assign status.cfg_known   = (cfg_index == CFG_PATTERN_BYTES) ||
                              (cfg_index == CFG_PATTERN_LENGTH);
  assign status.build_done  = (bld_i >= used_len);
  assign status.step_done   = skip_r || (j == '0) || j_hit;
  assign status.out_blocked = ends_r && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= '0;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        failure_table[k] <= '0;
      end
      matched_prefix <= '0;
      found_flag     <= 1'b0;
      bld_i          <= CNT_W'(1);
      bld_len        <= '0;
      out_valid      <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if (cmd.finish && ends_r) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cmd.cfg_write) begin
        if (cfg_index == CFG_PATTERN_BYTES) begin
          pattern_bytes <= cfg_data[PAT_BYTES_W-1:0];
        end
        if (cfg_index == CFG_PATTERN_LENGTH) begin
          pattern_length <= cfg_data[PAT_LEN_W-1:0];
        end
        if (status.cfg_known) begin
          for (int k = 0; k < PATTERN_MAX; k++) begin
            failure_table[k] <= '0;
          end
          matched_prefix <= '0;
          found_flag     <= 1'b0;
          bld_i          <= CNT_W'(1);
          bld_len        <= '0;
        end
      end

      if (cmd.build_step) begin
        if (pat_i == pat_len) begin
          bld_len                           <= bld_len + 1'b1;
          failure_table[bld_i[IDX_W-1:0]] <= bld_len + 1'b1;
          bld_i                             <= bld_i + 1'b1;
        end else if (bld_len != '0) begin
          bld_len <= ft_rd;
        end else begin
          bld_i <= bld_i + 1'b1;
        end
      end

      if (cmd.finish) begin
        if (ends_r) begin
          matched_prefix <= '0;
          found_flag     <= 1'b0;
        end else if (!skip_r) begin
          matched_prefix <= new_j;
          if (new_found) begin
            found_flag <= 1'b1;
          end
        end
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      char_r <= fold_byte(text_char);
      ends_r <= end_of_text || empty_text;
      skip_r <= empty_text || (used_len == '0) || found_flag;
      j      <= (matched_prefix >= used_len) ? '0 : matched_prefix;
    end else if (cmd.search_step) begin
      j <= ft_rd;
    end
    if (cmd.finish && ends_r) begin
      found <= (used_len == '0) || found_flag || new_found;
    end
  end

  `ASSERT_IMPL(a_prefix_below_len, !found_flag && (used_len != '0), matched_prefix < used_len, "matched prefix reached the pattern length without a match")
  `ASSERT_IMPL(a_search_in_range, cmd.search_step, (j < used_len) && (j != '0), "failure link followed from an index outside the pattern")
  `ASSERT_IMPL(a_build_order, cmd.build_step, (bld_len < bld_i) && (bld_i < used_len), "table build pointers out of order")
  `ASSERT_NEXT(a_result_follows_end, cmd.finish && ends_r, out_valid, "text ended without a result")

endmodule
